// ===== rtl/core/decimal_text_to_int128_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text parser
// Immediate-implication and next-cycle checks, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INT128_PARSER_ASSERT_SVH
`define DECIMAL_TEXT_TO_INT128_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/dtip_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal text parser package
// Constants and helper functions for the 128-bit decimal text parser.
// ----------------------------------------------------------------------------
package dtip_pkg;

   localparam int MAX_DIGITS = 39;
   localparam int DIGIT_COUNT_WIDTH = $clog2(MAX_DIGITS + 1);
   localparam int VALUE_WIDTH = 128;
   localparam int HALF_WIDTH = VALUE_WIDTH / 2;

   localparam logic [7:0] CHAR_TERMINATOR = 8'd0;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0d;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ===== rtl/core/decimal_text_to_int128_parser.sv =====
// ----------------------------------------------------------------------------
// Decimal text to 128-bit integer parser
// Converts a zero-terminated byte string of decimal digits, with an optional
// minus in signed mode and optional trailing whitespace, into a 128-bit value.
//
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_char_code[7:0]
// rsp      out        rsp_valid/stall    rsp_value_low, rsp_value_high, rsp_status
// csr      in         csr_valid/ready    csr_data (signed_mode)
//
// One byte is accepted per cycle into the input register while the input is
// not stalled, and is processed from there; a terminator's result goes from
// the input register into the output register once it is consumed. The digit
// step is a short shift-and-add on 128 bits and the final negation is one
// 128-bit add between these registers. Reset returns the string state and
// signed_mode to zero. The input stalls only when a terminator waits for an
// output register that still holds a result the consumer has not taken.
// ----------------------------------------------------------------------------
`include "decimal_text_to_int128_parser_assert.svh"

module decimal_text_to_int128_parser
   import dtip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HALF_WIDTH-1:0] rsp_value_low,
   output logic [HALF_WIDTH-1:0] rsp_value_high,
   output logic                  rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_MINUS = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_TRAIL = 3'd3;
   localparam logic [2:0] PH_ERROR = 3'd4;

   logic                         signed_mode_ff;
   logic                         in_valid_ff;
   logic [7:0]                   in_char_ff;
   logic [2:0]                   phase_ff, phase_in;
   value_type                    accum_ff, accum_in;
   logic [DIGIT_COUNT_WIDTH-1:0] digit_count_ff, digit_count_in;
   logic                         is_negative_ff, is_negative_in;
   logic                         rsp_valid_ff;
   value_type                    rsp_value_ff, rsp_value_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic      is_term;
   logic      consume;
   logic      char_digit;
   logic      char_blank;
   logic [3:0] digit_value;
   value_type times_ten;
   value_type negated;

   assign csr_ready = 1'b1;

   assign is_term = (in_char_ff == CHAR_TERMINATOR);
   assign consume = in_valid_ff && (!is_term || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !consume;

   assign char_digit = is_digit(in_char_ff);
   assign char_blank = is_blank(in_char_ff);
   assign digit_value = 4'(in_char_ff - CHAR_ZERO);
   assign times_ten = (accum_ff << 3) + (accum_ff << 1)
                    + {{(VALUE_WIDTH-4){1'b0}}, digit_value};
   assign negated = ~accum_ff + value_type'(1);

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      digit_count_in = digit_count_ff;
      is_negative_in = is_negative_ff;
      rsp_value_in = '0;
      rsp_status_in = STATUS_INVALID;
      if (is_term) begin
         if ((phase_ff == PH_DIGITS) || (phase_ff == PH_TRAIL)) begin
            rsp_value_in = is_negative_ff ? negated : accum_ff;
            rsp_status_in = STATUS_OK;
         end
         phase_in = PH_START;
         accum_in = '0;
         digit_count_in = '0;
         is_negative_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if ((in_char_ff == CHAR_MINUS) && signed_mode_ff) begin
                  is_negative_in = 1'b1;
                  phase_in = PH_MINUS;
               end else if (char_digit) begin
                  accum_in = times_ten;
                  digit_count_in = DIGIT_COUNT_WIDTH'(1);
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_MINUS: begin
               if (char_digit) begin
                  accum_in = times_ten;
                  digit_count_in = DIGIT_COUNT_WIDTH'(1);
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_DIGITS: begin
               if (char_digit && (digit_count_ff < DIGIT_COUNT_WIDTH'(MAX_DIGITS))) begin
                  accum_in = times_ten;
                  digit_count_in = digit_count_ff + DIGIT_COUNT_WIDTH'(1);
               end else if (char_blank) begin
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TRAIL: begin
               if (!char_blank) begin
                  phase_in = PH_ERROR;
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
         in_valid_ff <= 1'b0;
         phase_ff <= PH_START;
         accum_ff <= '0;
         digit_count_ff <= '0;
         is_negative_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            signed_mode_ff <= csr_data;
         end
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         if (consume) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            digit_count_ff <= digit_count_in;
            is_negative_ff <= is_negative_in;
         end
         if (consume && is_term) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
      end
      if (consume && is_term) begin
         rsp_value_ff <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value_low = rsp_value_ff[HALF_WIDTH-1:0];
   assign rsp_value_high = rsp_value_ff[VALUE_WIDTH-1:HALF_WIDTH];
   assign rsp_status = rsp_status_ff;

   `DTI_ASSERT_NOW(a_count_bound, 1'b1, digit_count_ff <= DIGIT_COUNT_WIDTH'(MAX_DIGITS))
   `DTI_ASSERT_NOW(a_invalid_zero, rsp_valid_ff && (rsp_status_ff == STATUS_INVALID),
      rsp_value_ff == '0)
   `DTI_ASSERT_NOW(a_start_clear, phase_ff == PH_START,
      (accum_ff == '0) && (digit_count_ff == '0) && !is_negative_ff)
   `DTI_ASSERT_NOW(a_minus_flag, phase_ff == PH_MINUS, is_negative_ff && (digit_count_ff == '0))
   `DTI_ASSERT_NEXT(a_term_result, consume && is_term, rsp_valid_ff)

endmodule

// ===== tb/decimal_text_to_int128_parser_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the decimal text to 128-bit integer parser
// Streams zero-terminated byte strings into the parser in both signed modes and
// predicts each result from a bit-accurate model of the digit scan. Directed
// strings cover the field extremes and the syntax corner cases. Random strings
// are mostly well-formed numbers with broken and noisy strings mixed in. Both
// channels idle and stall at random, and one long receiver stall backs the
// parser up into its input.
// ----------------------------------------------------------------------------
module decimal_text_to_int128_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtip_pkg::*;

   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 135;
   localparam int TIMEOUT_NS = 10_000_000;

   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_TRAIL,
      SCAN_ERROR
   } scan_phase_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   status;
   } parse_result_type;

   class int128_text_scoreboard_type;
      logic                   signed_mode;
      scan_phase_type         phase;
      logic [VALUE_WIDTH-1:0] accum;
      int unsigned            digit_count;
      logic                   negative;
      parse_result_type       parsed_q[$];
      int unsigned            error_count;
      int unsigned            live_items;

      function new();
         signed_mode = 1'b0;
         error_count = 0;
         live_items = 0;
         restart();
      endfunction

      function void restart();
         phase = SCAN_START;
         accum = '0;
         digit_count = 0;
         negative = 1'b0;
      endfunction

      function void take_digit(input logic [7:0] code);
         accum = accum * 10 + (code - CHAR_ZERO);
         digit_count++;
         phase = SCAN_DIGITS;
      endfunction

      function void note_item(input logic [7:0] code);
         logic             digit;
         logic             blank;
         parse_result_type res;
         digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
         blank = (code == CHAR_SPACE) || ((code >= CHAR_TAB) && (code <= CHAR_CR));
         if (phase != SCAN_ERROR || code == CHAR_TERMINATOR) live_items++;
         if (code == CHAR_TERMINATOR) begin
            if (phase == SCAN_DIGITS || phase == SCAN_TRAIL) begin
               res.value = negative ? -accum : accum;
               res.status = STATUS_OK;
            end else begin
               res.value = '0;
               res.status = STATUS_INVALID;
            end
            parsed_q.push_back(res);
            restart();
         end else begin
            case (phase)
               SCAN_START: begin
                  if (code == CHAR_MINUS && signed_mode) begin
                     negative = 1'b1;
                     phase = SCAN_SIGN;
                  end else if (digit) begin
                     take_digit(code);
                  end else begin
                     phase = SCAN_ERROR;
                  end
               end
               SCAN_SIGN: begin
                  if (digit) take_digit(code);
                  else phase = SCAN_ERROR;
               end
               SCAN_DIGITS: begin
                  if (digit && digit_count < MAX_DIGITS) take_digit(code);
                  else if (blank) phase = SCAN_TRAIL;
                  else phase = SCAN_ERROR;
               end
               SCAN_TRAIL: begin
                  if (!blank) phase = SCAN_ERROR;
               end
               default: phase = SCAN_ERROR;
            endcase
         end
      endfunction

      function void check_result(input logic [HALF_WIDTH-1:0] low,
                                 input logic [HALF_WIDTH-1:0] high,
                                 input logic status);
         parse_result_type want;
         if (parsed_q.size() == 0) begin
            $error("unexpected result: value_high=%h value_low=%h status=%b",
                   high, low, status);
            error_count++;
         end else begin
            want = parsed_q.pop_front();
            if (low !== want.value[HALF_WIDTH-1:0]) begin
               $error("value_low: expected %h, actual %h", want.value[HALF_WIDTH-1:0], low);
               error_count++;
            end
            if (high !== want.value[VALUE_WIDTH-1:HALF_WIDTH]) begin
               $error("value_high: expected %h, actual %h",
                      want.value[VALUE_WIDTH-1:HALF_WIDTH], high);
               error_count++;
            end
            if (status !== want.status) begin
               $error("status: expected %b, actual %b", want.status, status);
               error_count++;
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_char_code;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [HALF_WIDTH-1:0] rsp_value_low;
   logic [HALF_WIDTH-1:0] rsp_value_high;
   logic                  rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_data;

   int128_text_scoreboard_type sb;
   logic [7:0]            line_q[$];
   logic                  req_quiet = 1'b0;
   logic                  rsp_quiet = 1'b0;
   int unsigned           hold_cycles = 0;

   decimal_text_to_int128_parser DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_low  (rsp_value_low),
      .rsp_value_high (rsp_value_high),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned pick_gap(input logic quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_text(input string text);
      for (int i = 0; i < text.len(); i++) line_q.push_back(text[i]);
   endfunction

   function automatic void add_digits(input int count, input int digit);
      for (int i = 0; i < count; i++)
         line_q.push_back(CHAR_ZERO + 8'((digit < 0) ? $urandom_range(0, 9) : digit));
   endfunction

   function automatic void add_blank();
      int unsigned pick;
      pick = $urandom_range(0, 5);
      line_q.push_back((pick == 5) ? CHAR_SPACE : CHAR_TAB + 8'(pick));
   endfunction

   function automatic void build_random_line(input logic minus_ok);
      int unsigned kind;
      int unsigned pick;
      int unsigned len;
      int unsigned pos;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) len = $urandom_range(1, 12);
         else if (pick < 85) len = $urandom_range(13, 30);
         else if (pick < 95) len = $urandom_range(37, 39);
         else len = $urandom_range(40, 42);
         if (minus_ok && $urandom_range(0, 1) == 1) line_q.push_back(CHAR_MINUS);
         add_digits(len, ($urandom_range(0, 3) == 0) ? 9 : -1);
         repeat ($urandom_range(0, 3)) add_blank();
         if (kind >= 70) begin
            pos = $urandom_range(0, line_q.size());
            case ($urandom_range(0, 3))
               0: line_q.insert(pos, 8'($urandom_range(1, 255)));
               1: line_q.insert(pos, CHAR_MINUS);
               2: line_q.insert(0, ($urandom_range(0, 1) == 1) ? CHAR_PLUS : CHAR_SPACE);
               default: begin
                  add_blank();
                  add_digits(1, -1);
               end
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 8)) line_q.push_back(8'($urandom_range(1, 255)));
      end
      line_q.push_back(CHAR_TERMINATOR);
   endfunction

   task automatic send_char(input logic [7:0] code);
      int unsigned gap;
      req_valid <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      sb.note_item(code);
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i]);
      line_q.delete();
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (sb.parsed_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.signed_mode = mode;
   endtask

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap(rsp_quiet);
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_value_low, rsp_value_high, rsp_status);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_start;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_code <= CHAR_TERMINATOR;
      csr_valid <= 1'b0;
      csr_data <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_text("0");
      line_q.push_back(CHAR_TERMINATOR);
      line_q.push_back(CHAR_TERMINATOR);
      add_text("-5");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("+5");
      line_q.push_back(CHAR_TERMINATOR);
      add_text(" 5");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("12");
      for (int c = CHAR_TAB; c <= CHAR_CR; c++) line_q.push_back(8'(c));
      line_q.push_back(CHAR_SPACE);
      line_q.push_back(CHAR_TERMINATOR);
      add_text("7 8");
      line_q.push_back(CHAR_TERMINATOR);
      add_digits(39, 9);
      line_q.push_back(CHAR_TERMINATOR);
      add_digits(40, 1);
      line_q.push_back(CHAR_TERMINATOR);
      line_q.push_back(8'hff);
      line_q.push_back(CHAR_TERMINATOR);
      send_line();
      drain();

      write_mode(1'b1);
      add_text("-0");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("-");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("-170141183460469231731687303715884105728");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("--1");
      line_q.push_back(CHAR_TERMINATOR);
      add_text("-9 ");
      line_q.push_back(CHAR_TERMINATOR);
      send_line();

      for (int p = 0; p < 8; p++) begin
         drain();
         write_mode(p[0]);
         req_quiet = (p == 2 || p == 5);
         rsp_quiet = (p == 2);
         if (p == 3) begin
            req_quiet = 1'b1;
            hold_cycles = LONG_HOLD;
            repeat (40) begin
               add_digits(1, -1);
               line_q.push_back(CHAR_TERMINATOR);
               send_line();
            end
            req_quiet = 1'b0;
         end
         phase_start = sb.live_items;
         while (sb.live_items - phase_start < PHASE_ITEMS) begin
            build_random_line(p[0]);
            send_line();
         end
      end
      drain();

      if (sb.error_count == 0 && sb.parsed_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
